[hw/rtl/ppsd_pkg.sv]
`default_nettype none
package ppsd_pkg;

   localparam int NUM_PIXELS = 65536;
   localparam int PIXEL_BITS = 16;
   localparam int IDX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

   localparam int S1_W = 37;
   localparam int S2_W = 60;
   localparam int SQ_W = 64;
   localparam int V_W = 34;

   localparam int QDEPTH = 8;
   localparam int QAW = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int REQ_W = 40;
   localparam int RSP_W = 40;

   localparam logic [1:0] MODE_ACC = 2'd0;
   localparam logic [1:0] MODE_ACC_CALC = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] REG_WEIGHT = 2'd0;
   localparam logic [1:0] REG_OFFSET = 2'd1;
   localparam logic [1:0] REG_FRAME_COUNT = 2'd2;

   typedef struct packed {
      logic [15:0] idx;
      logic signed [S1_W-1:0] s1;
      logic [S2_W-1:0] s2;
   } job_type;

endpackage
`default_nettype wire

[hw/rtl/ppsd_ram.sv]
`default_nettype none
module ppsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

[hw/rtl/ppsd_front.sv]
`default_nettype none
module ppsd_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ppsd_pkg::REQ_W-1:0]           req_tdata,
   input  wire logic [15:0]                          weight,
   input  wire logic [15:0]                          offset,
   input  wire logic [ppsd_pkg::QCNT_W-1:0]          q_count,
   output logic                                      push,
   output ppsd_pkg::job_type                         push_job
);

   localparam int IW = ppsd_pkg::IDX_W;
   localparam int S1W = ppsd_pkg::S1_W;
   localparam int S2W = ppsd_pkg::S2_W;
   localparam int VW = ppsd_pkg::V_W;
   localparam int PCW = ppsd_pkg::QCNT_W + 1;

   logic          clr_busy_ff, clr_busy_in;
   logic [IW-1:0] clr_addr_ff, clr_addr_in;

   logic        accept, keep;
   logic [1:0]  in_mode;
   logic [15:0] in_idx, in_val;

   logic                      s1_valid_ff, s1_valid_in;
   logic [1:0]                s1_mode_ff;
   logic [15:0]               s1_idx_ff;
   logic [ppsd_pkg::PIXEL_BITS-1:0] s1_raw_ff;

   logic                      s2_valid_ff, s2_valid_in;
   logic [1:0]                s2_mode_ff;
   logic [15:0]               s2_idx_ff;
   logic signed [VW-1:0]      s2_v_ff, s2_v_in;

   logic                      s3_valid_ff, s3_valid_in;
   logic [1:0]                s3_mode_ff;
   logic [15:0]               s3_idx_ff;
   logic signed [VW-1:0]      s3_v_ff;
   logic [ppsd_pkg::SQ_W-1:0] s3_sq_ff, s3_sq_in;

   logic                      fw_valid_ff, fw_valid_in;
   logic [15:0]               fw_idx_ff;
   logic signed [S1W-1:0]     fw_s1_ff;
   logic [S2W-1:0]            fw_s2_ff;

   logic signed [16:0]    diff;
   logic signed [VW-1:0]  diff_ext, w_ext;
   logic [VW-1:0]         v_abs;
   logic [31:0]           mag;

   logic [S1W-1:0]        rd_s1;
   logic [S2W-1:0]        rd_s2;
   logic signed [S1W-1:0] old_s1, new_s1;
   logic [S2W-1:0]        old_s2, new_s2;
   logic signed [S1W:0]   sum1;
   logic [S2W:0]          sum2;
   logic                  sat2;

   logic           ram_we;
   logic [IW-1:0]  ram_waddr;
   logic [S1W-1:0] ram_wd1;
   logic [S2W-1:0] ram_wd2;

   logic [PCW-1:0] pending;

   assign in_mode = req_tdata[1:0];
   assign in_idx = req_tdata[17:2];
   assign in_val = req_tdata[33:18];

   // A compute item is counted against the queue from the moment it is taken.
   assign pending = PCW'(q_count)
      + PCW'(s1_valid_ff && s1_mode_ff == ppsd_pkg::MODE_ACC_CALC)
      + PCW'(s2_valid_ff && s2_mode_ff == ppsd_pkg::MODE_ACC_CALC)
      + PCW'(s3_valid_ff && s3_mode_ff == ppsd_pkg::MODE_ACC_CALC);

   assign req_tready = !clr_busy_ff && (pending < PCW'(ppsd_pkg::QDEPTH));
   assign accept = req_tvalid && req_tready;
   assign keep = (in_mode != ppsd_pkg::MODE_UNUSED) && (32'(in_idx) < ppsd_pkg::NUM_PIXELS);

   assign clr_busy_in = clr_busy_ff && (32'(clr_addr_ff) != ppsd_pkg::NUM_PIXELS - 1);
   assign clr_addr_in = clr_addr_ff + IW'(1);

   assign s1_valid_in = accept && keep;

   assign diff = $signed({1'b0, 16'(s1_raw_ff)}) - $signed({1'b0, offset});
   assign diff_ext = VW'(diff);
   assign w_ext = $signed({{(VW - 16){1'b0}}, weight});
   assign s2_v_in = diff_ext * w_ext;
   assign s2_valid_in = s1_valid_ff;

   assign v_abs = s2_v_ff[VW-1] ? VW'(-s2_v_ff) : VW'(s2_v_ff);
   assign mag = v_abs[31:0];
   assign s3_sq_in = {32'd0, mag} * {32'd0, mag};
   assign s3_valid_in = s2_valid_ff;

   // The read issued from stage 2 missed the write of the item just ahead.
   assign old_s1 = (fw_valid_ff && fw_idx_ff == s3_idx_ff) ? fw_s1_ff : $signed(rd_s1);
   assign old_s2 = (fw_valid_ff && fw_idx_ff == s3_idx_ff) ? fw_s2_ff : rd_s2;

   assign sum1 = (S1W + 1)'(old_s1) + (S1W + 1)'(s3_v_ff);
   assign sum2 = {1'b0, old_s2} + {1'b0, s3_sq_ff[S2W-1:0]};
   assign sat2 = (|s3_sq_ff[ppsd_pkg::SQ_W-1:S2W]) || sum2[S2W];

   always_comb begin
      if (s3_mode_ff == ppsd_pkg::MODE_CLEAR) begin
         new_s1 = '0;
         new_s2 = '0;
      end else begin
         if (sum1[S1W] != sum1[S1W-1]) begin
            new_s1 = sum1[S1W] ? {1'b1, {(S1W - 1){1'b0}}} : {1'b0, {(S1W - 1){1'b1}}};
         end else begin
            new_s1 = sum1[S1W-1:0];
         end
         new_s2 = sat2 ? {S2W{1'b1}} : sum2[S2W-1:0];
      end
   end

   assign ram_we = clr_busy_ff || s3_valid_ff;
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : s3_idx_ff[IW-1:0];
   assign ram_wd1 = clr_busy_ff ? '0 : new_s1;
   assign ram_wd2 = clr_busy_ff ? '0 : new_s2;

   assign fw_valid_in = fw_valid_ff || s3_valid_ff;

   assign push = s3_valid_ff && s3_mode_ff == ppsd_pkg::MODE_ACC_CALC;
   assign push_job = '{idx: s3_idx_ff, s1: new_s1, s2: new_s2};

   ppsd_ram #(.WIDTH(S1W), .DEPTH(ppsd_pkg::NUM_PIXELS)) u_ram_s1 (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wd1),
      .raddr (s2_idx_ff[IW-1:0]),
      .rdata (rd_s1)
   );

   ppsd_ram #(.WIDTH(S2W), .DEPTH(ppsd_pkg::NUM_PIXELS)) u_ram_s2 (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wd2),
      .raddr (s2_idx_ff[IW-1:0]),
      .rdata (rd_s2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         fw_valid_ff <= fw_valid_in;
      end
      s1_mode_ff <= in_mode;
      s1_idx_ff <= in_idx;
      s1_raw_ff <= in_val[ppsd_pkg::PIXEL_BITS-1:0];
      s2_mode_ff <= s1_mode_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_v_ff <= s2_v_in;
      s3_mode_ff <= s2_mode_ff;
      s3_idx_ff <= s2_idx_ff;
      s3_v_ff <= s2_v_ff;
      s3_sq_ff <= s3_sq_in;
      if (s3_valid_ff) begin
         fw_idx_ff <= s3_idx_ff;
         fw_s1_ff <= new_s1;
         fw_s2_ff <= new_s2;
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= PCW'(ppsd_pkg::QDEPTH))
      else $error("compute items exceed queue room");

endmodule
`default_nettype wire

[hw/rtl/ppsd_queue.sv]
`default_nettype none
module ppsd_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire ppsd_pkg::job_type           push_job,
   input  wire logic                        pop,
   output logic                             q_valid,
   output ppsd_pkg::job_type                q_job,
   output logic [ppsd_pkg::QCNT_W-1:0]      q_count
);

   localparam int AW = ppsd_pkg::QAW;

   ppsd_pkg::job_type entry_ff [ppsd_pkg::QDEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ppsd_pkg::QCNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = (32'(wr_ptr_ff) == ppsd_pkg::QDEPTH - 1) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_ptr_in = (32'(rd_ptr_ff) == ppsd_pkg::QDEPTH - 1) ? '0 : rd_ptr_ff + AW'(1);
   assign count_in = count_ff + ppsd_pkg::QCNT_W'(push) - ppsd_pkg::QCNT_W'(pop);

   assign q_valid = count_ff != '0;
   assign q_job = entry_ff[rd_ptr_ff];
   assign q_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> 32'(count_ff) < ppsd_pkg::QDEPTH)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

endmodule
`default_nettype wire

[hw/rtl/ppsd_back.sv]
`default_nettype none
module ppsd_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [12:0]                     frame_count,
   input  wire logic                            q_valid,
   input  wire ppsd_pkg::job_type               q_job,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [ppsd_pkg::RSP_W-1:0]           rsp_tdata
);

   localparam int S2W = ppsd_pkg::S2_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_VAR,
      ST_SQRT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [15:0]    idx_ff, idx_in;
   logic [S2W-1:0] dvd1_ff, dvd1_in;
   logic [S2W-1:0] dvd2_ff, dvd2_in;
   logic [12:0]    rem1_ff, rem1_in;
   logic [12:0]    rem2_ff, rem2_in;
   logic [S2W-1:0] msq_ff, msq_in;
   logic           big_ff, big_in;
   logic [S2W-1:0] x_ff, x_in;
   logic [S2W-1:0] res_ff, res_in;
   logic [S2W-1:0] bit_ff, bit_in;
   logic           out_valid_ff, out_valid_in;
   logic [15:0]    out_idx_ff, out_idx_in;
   logic [23:0]    out_std_ff, out_std_in;

   logic [12:0]    n;
   logic [13:0]    t1, t2;
   logic           ge1, ge2;
   logic [S2W:0]   trial;
   logic [ppsd_pkg::S1_W-1:0] s1_abs;
   logic [30:0]    rounded;

   assign n = (frame_count == '0) ? 13'd1 : frame_count;
   assign s1_abs = q_job.s1[ppsd_pkg::S1_W-1] ? ppsd_pkg::S1_W'(-q_job.s1)
                                              : ppsd_pkg::S1_W'(q_job.s1);

   // One quotient bit a cycle for both sums; quotients shift into the dividends.
   assign t1 = {rem1_ff, dvd1_ff[S2W-1]};
   assign t2 = {rem2_ff, dvd2_ff[S2W-1]};
   assign ge1 = t1 >= {1'b0, n};
   assign ge2 = t2 >= {1'b0, n};

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign rounded = 31'(res_ff[29:0]) + 31'd128;

   assign pop = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      dvd1_in = dvd1_ff;
      dvd2_in = dvd2_ff;
      rem1_in = rem1_ff;
      rem2_in = rem2_ff;
      msq_in = msq_ff;
      big_in = big_ff;
      x_in = x_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_idx_in = out_idx_ff;
      out_std_in = out_std_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               idx_in = q_job.idx;
               dvd1_in = S2W'(s1_abs);
               dvd2_in = q_job.s2;
               rem1_in = '0;
               rem2_in = '0;
               cnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem1_in = ge1 ? 13'(t1 - {1'b0, n}) : t1[12:0];
            rem2_in = ge2 ? 13'(t2 - {1'b0, n}) : t2[12:0];
            dvd1_in = {dvd1_ff[S2W-2:0], ge1};
            dvd2_in = {dvd2_ff[S2W-2:0], ge2};
            cnt_in = cnt_ff + 6'd1;
            if (32'(cnt_ff) == S2W - 1) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            big_in = |dvd1_ff[S2W-1:30];
            msq_in = {30'd0, dvd1_ff[29:0]} * {30'd0, dvd1_ff[29:0]};
            state_in = ST_VAR;
         end
         ST_VAR: begin
            x_in = (big_ff || msq_ff > dvd2_ff) ? '0 : dvd2_ff - msq_ff;
            res_in = '0;
            bit_in = S2W'(1) << (S2W - 2);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               if ({1'b0, x_ff} >= trial) begin
                  x_in = S2W'({1'b0, x_ff} - trial);
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_idx_in = idx_ff;
               out_std_in = 24'(rounded[30:8]);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      dvd1_ff <= dvd1_in;
      dvd2_ff <= dvd2_in;
      rem1_ff <= rem1_in;
      rem2_ff <= rem2_in;
      msq_ff <= msq_in;
      big_ff <= big_in;
      x_ff <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      out_idx_ff <= out_idx_in;
      out_std_ff <= out_std_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {out_std_ff, out_idx_ff};

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> 32'(cnt_ff) < S2W)
      else $error("divider ran past its last step");

endmodule
`default_nettype wire

[hw/rtl/per_pixel_std_dev_accumulator.sv]
// Accumulate and clear items: one transfer per cycle while req_tready is high, through stages
// s1, s2 and s3 to the sum write. Compute items go one at a time through the shared divide and
// square root unit, which sets their rate; up to eight wait in the queue ahead of it, and once
// the queue and the compute items in flight reach eight, req_tready goes low for all items.
// Reset is synchronous; afterwards both sum memories are zeroed at one pixel a cycle
// with req_tready low, and the registers return to weight 256, offset 0, count 1.
`default_nettype none
module per_pixel_std_dev_accumulator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // mode [1:0], pixel_index [17:2], pixel_value [33:18], zero [39:34]
   input  wire logic [ppsd_pkg::REQ_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // out_index [15:0], std_dev [39:16]
   output logic [ppsd_pkg::RSP_W-1:0]       rsp_tdata,
   input  wire logic                        csr_we,
   input  wire logic [1:0]                  csr_addr,
   input  wire logic [15:0]                 csr_wdata
);

   logic [15:0] weight_ff;
   logic [15:0] offset_ff;
   logic [12:0] frame_count_ff;

   logic                        push, pop, q_valid;
   ppsd_pkg::job_type           push_job, q_job;
   logic [ppsd_pkg::QCNT_W-1:0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= 16'd256;
         offset_ff <= 16'd0;
         frame_count_ff <= 13'd1;
      end else if (csr_we) begin
         case (csr_addr)
            ppsd_pkg::REG_WEIGHT: begin
               weight_ff <= csr_wdata;
            end
            ppsd_pkg::REG_OFFSET: begin
               offset_ff <= csr_wdata;
            end
            ppsd_pkg::REG_FRAME_COUNT: begin
               frame_count_ff <= csr_wdata[12:0];
            end
            default: begin
            end
         endcase
      end
   end

   ppsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .weight     (weight_ff),
      .offset     (offset_ff),
      .q_count    (q_count),
      .push       (push),
      .push_job   (push_job)
   );

   ppsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_job    (q_job),
      .q_count  (q_count)
   );

   ppsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_count (frame_count_ff),
      .q_valid     (q_valid),
      .q_job       (q_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire
